@@ src/bmoe_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, operation codes and the command and status structs of the byte memory engine
// no dependencies

package bmoe_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LEN_W     = 17;
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CMP_W     = BYTE_W + 1;

    typedef logic [OP_W-1:0] op_code_t;

    localparam op_code_t OP_WRITE   = 3'd0;
    localparam op_code_t OP_READ    = 3'd1;
    localparam op_code_t OP_FILL    = 3'd2;
    localparam op_code_t OP_MOVE    = 3'd3;
    localparam op_code_t OP_COMPARE = 3'd4;
    localparam op_code_t OP_STRLEN  = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;          // capture a new transaction
        logic fill_step;     // write the fill byte at the destination pointer
        logic rd_issue;      // read both pointers and advance them (move, compare)
        logic move_write;    // write the byte read last cycle to its destination
        logic str_issue;     // read the string pointer and advance it
        logic read_issue;    // single byte read
        logic read_capture;
        logic cmp_capture;
        logic str_count;
        logic str_capture;
        logic str_noterm;
        logic out_load;
    } bmoe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rem_zero;
        logic pend_valid;
        logic mismatch;
        logic str_zero;
        logic str_end;
    } bmoe_status_t;

endpackage

@@ src/bmoe_dp.sv @@
`timescale 1ns / 1ps
// datapath: byte memory, pointers, counters, read pipeline and result registers
// depends on bmoe_pkg

module bmoe_dp
    import bmoe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bmoe_cmd_t                cmd,
    input  logic [OP_W-1:0]          operation,
    input  logic [ADDR_W-1:0]        addr_a,
    input  logic [ADDR_W-1:0]        addr_b,
    input  logic [LEN_W-1:0]         length,
    input  logic [BYTE_W-1:0]        byte_value,
    output bmoe_status_t             status,
    output logic [BYTE_W-1:0]        read_data,
    output logic signed [CMP_W-1:0]  compare_result,
    output logic [LEN_W-1:0]         string_length,
    output logic                     no_terminator
);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];

    logic [ADDR_W-1:0]       ptr_a_reg, ptr_a_next;
    logic [ADDR_W-1:0]       ptr_b_reg, ptr_b_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic                    down_reg, down_next;
    logic [BYTE_W-1:0]       val_reg, val_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic                    str_end_reg, str_end_next;

    logic [BYTE_W-1:0]       res_rd_reg, res_rd_next;
    logic signed [CMP_W-1:0] res_cmp_reg, res_cmp_next;
    logic [LEN_W-1:0]        res_len_reg, res_len_next;
    logic                    res_nt_reg, res_nt_next;

    logic [BYTE_W-1:0]       out_rd_reg;
    logic signed [CMP_W-1:0] out_cmp_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic                    out_nt_reg;

    logic [BYTE_W-1:0]       da_reg;
    logic [BYTE_W-1:0]       db_raw_reg;
    logic                    byp_hit_reg;
    logic [BYTE_W-1:0]       byp_data_reg;

    logic [BYTE_W-1:0]       db;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [BYTE_W-1:0]       mem_wd;
    logic                    re_a;
    logic                    re_b;
    logic                    go_down;
    logic [ADDR_W-1:0]       len_lo;

    // a write in the same cycle as the port b read wins
    assign db     = byp_hit_reg ? byp_data_reg : db_raw_reg;
    assign mem_we = cmd.fill_step | cmd.move_write;
    assign mem_wa = cmd.fill_step ? ptr_a_reg : pend_addr_reg;
    assign mem_wd = cmd.fill_step ? val_reg : db;
    assign re_a   = cmd.rd_issue | cmd.str_issue | cmd.read_issue;
    assign re_b   = cmd.rd_issue;
    assign len_lo = length[ADDR_W-1:0];

    // overlapping move with source below destination copies from the top down
    assign go_down = (operation == OP_MOVE) && (addr_b < addr_a) &&
                     (({1'b0, addr_b} + {1'b0, length}) > {2'b00, addr_a});

    assign status.rem_zero   = (rem_reg == '0);
    assign status.pend_valid = pend_valid_reg;
    assign status.mismatch   = pend_valid_reg && (da_reg != db);
    assign status.str_zero   = pend_valid_reg && (da_reg == '0);
    assign status.str_end    = str_end_reg;

    always_comb
    begin
        ptr_a_next      = ptr_a_reg;
        ptr_b_next      = ptr_b_reg;
        rem_next        = rem_reg;
        down_next       = down_reg;
        val_next        = val_reg;
        pend_valid_next = cmd.rd_issue | cmd.str_issue;
        pend_addr_next  = pend_addr_reg;
        cnt_next        = cnt_reg;
        str_end_next    = str_end_reg;
        res_rd_next     = res_rd_reg;
        res_cmp_next    = res_cmp_reg;
        res_len_next    = res_len_reg;
        res_nt_next     = res_nt_reg;

        if (cmd.load)
        begin
            down_next    = go_down;
            ptr_a_next   = go_down ? ADDR_W'(addr_a + len_lo - ADDR_W'(1)) : addr_a;
            ptr_b_next   = go_down ? ADDR_W'(addr_b + len_lo - ADDR_W'(1)) : addr_b;
            rem_next     = (operation == OP_WRITE) ? LEN_W'(1) : length;
            val_next     = byte_value;
            cnt_next     = '0;
            str_end_next = 1'b0;
            res_rd_next  = '0;
            res_cmp_next = '0;
            res_len_next = '0;
            res_nt_next  = 1'b0;
        end

        if (cmd.fill_step)
        begin
            ptr_a_next = ptr_a_reg + ADDR_W'(1);
            rem_next   = rem_reg - LEN_W'(1);
        end

        if (cmd.rd_issue)
        begin
            pend_addr_next = ptr_a_reg;
            ptr_a_next     = down_reg ? ptr_a_reg - ADDR_W'(1) : ptr_a_reg + ADDR_W'(1);
            ptr_b_next     = down_reg ? ptr_b_reg - ADDR_W'(1) : ptr_b_reg + ADDR_W'(1);
            rem_next       = rem_reg - LEN_W'(1);
        end

        if (cmd.str_issue)
        begin
            ptr_a_next   = ptr_a_reg + ADDR_W'(1);
            str_end_next = (ptr_a_reg == {ADDR_W{1'b1}});
        end

        if (cmd.str_count)
            cnt_next = cnt_reg + LEN_W'(1);

        if (cmd.read_capture)
            res_rd_next = da_reg;

        if (cmd.cmp_capture)
            res_cmp_next = CMP_W'({1'b0, da_reg} - {1'b0, db});

        if (cmd.str_capture)
        begin
            res_len_next = cnt_reg;
            res_nt_next  = cmd.str_noterm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            str_end_reg    <= 1'b0;
            down_reg       <= 1'b0;
            rem_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            str_end_reg    <= str_end_next;
            down_reg       <= down_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_a_reg     <= ptr_a_next;
        ptr_b_reg     <= ptr_b_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        cnt_reg       <= cnt_next;
        res_rd_reg    <= res_rd_next;
        res_cmp_reg   <= res_cmp_next;
        res_len_reg   <= res_len_next;
        res_nt_reg    <= res_nt_next;
        if (cmd.out_load)
        begin
            out_rd_reg  <= res_rd_reg;
            out_cmp_reg <= res_cmp_reg;
            out_len_reg <= res_len_reg;
            out_nt_reg  <= res_nt_reg;
        end
    end

    // byte memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (re_a)
            da_reg <= mem[ptr_a_reg];
        if (re_b)
        begin
            db_raw_reg   <= mem[ptr_b_reg];
            byp_hit_reg  <= mem_we && (mem_wa == ptr_b_reg);
            byp_data_reg <= mem_wd;
        end
    end

    assign read_data      = out_rd_reg;
    assign compare_result = out_cmp_reg;
    assign string_length  = out_len_reg;
    assign no_terminator  = out_nt_reg;

endmodule

@@ src/bmoe_ctrl.sv @@
`timescale 1ns / 1ps
// controller: sequences each transaction and runs both handshakes
// depends on bmoe_pkg

module bmoe_ctrl
    import bmoe_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] operation,
    output logic            out_valid,
    input  logic            out_ready,
    input  bmoe_status_t    status,
    output bmoe_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FILL      = 8'b0000_0010,
        S_MOVE      = 8'b0000_0100,
        S_CMP       = 8'b0000_1000,
        S_STR       = 8'b0001_0000,
        S_READ      = 8'b0010_0000,
        S_READ_DATA = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (operation) inside
                        OP_WRITE, OP_FILL: state_next = S_FILL;
                        OP_READ:           state_next = S_READ;
                        OP_MOVE:           state_next = S_MOVE;
                        OP_COMPARE:        state_next = S_CMP;
                        OP_STRLEN:         state_next = S_STR;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                if (!status.rem_zero)
                    cmd.fill_step = 1'b1;
                else
                    state_next = S_DONE;
            end
            S_MOVE:
            begin
                cmd.move_write = status.pend_valid;
                cmd.rd_issue   = !status.rem_zero;
                if (status.rem_zero && !status.pend_valid)
                    state_next = S_DONE;
            end
            S_CMP:
            begin
                if (status.mismatch)
                begin
                    cmd.cmp_capture = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.rd_issue = !status.rem_zero;
                    if (status.rem_zero && !status.pend_valid)
                        state_next = S_DONE;
                end
            end
            S_STR:
            begin
                if (status.str_zero)
                begin
                    cmd.str_capture = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.str_count = status.pend_valid;
                    cmd.str_issue = !status.str_end;
                    // top of memory passed without a zero byte
                    if (status.str_end && !status.pend_valid)
                    begin
                        cmd.str_capture = 1'b1;
                        cmd.str_noterm  = 1'b1;
                        state_next      = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !cmd.out_load)
        else $error("result register overwritten while held");

    // an accepted transaction always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("accepted transaction dropped");

    // move write-back only follows a read issued the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_write |-> $past(cmd.rd_issue))
        else $error("move write without a preceding read");

    // a new result appears only after passing through the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");
`endif

endmodule

@@ src/byte_memory_op_engine_top.sv @@
`timescale 1ns / 1ps
// top level of the byte memory operation engine: write, read, fill, move, compare, string length
// depends on bmoe_pkg, bmoe_ctrl, bmoe_dp
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | operation, addr_a, addr_b, length, byte_value
//  out     | out_valid / out_ready| read_data, compare_result, string_length, no_terminator
//
// one transaction at a time; one memory access per cycle per port
// write and fill run the fill loop, read an issue and a data state, move, compare and
// string length their per-byte loops, then all the done state; the per-byte loop sets the rate
// asynchronous active-low reset clears control only; memory contents are undefined until written
// a new transaction is accepted while the previous result waits at the output register

module byte_memory_op_engine_top
    import bmoe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          operation,
    input  logic [ADDR_W-1:0]        addr_a,
    input  logic [ADDR_W-1:0]        addr_b,
    input  logic [LEN_W-1:0]         length,
    input  logic [BYTE_W-1:0]        byte_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BYTE_W-1:0]        read_data,
    output logic signed [CMP_W-1:0]  compare_result,
    output logic [LEN_W-1:0]         string_length,
    output logic                     no_terminator
);

    bmoe_cmd_t    cmd;
    bmoe_status_t status;

    bmoe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmoe_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (operation),
        .addr_a         (addr_a),
        .addr_b         (addr_b),
        .length         (length),
        .byte_value     (byte_value),
        .status         (status),
        .read_data      (read_data),
        .compare_result (compare_result),
        .string_length  (string_length),
        .no_terminator  (no_terminator)
    );

endmodule
